// ----- design/acd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types and constants for the anchor chaining block.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int ADDR_MAX_W = 12;  // enough for the largest store
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TUPLE_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_THRESHOLD = 8'd1;

  localparam logic [7:0]  TUPLE_SIZE_RST = 8'd12;
  localparam logic [15:0] FRAC_RST       = 16'd13107;

  typedef struct packed {
    logic [7:0]  tuple_size;
    logic [15:0] frac_threshold;
  } acd_cfg_t;

  // one classified input beat
  typedef struct packed {
    logic [15:0]           read_pos;
    logic [31:0]           genome_pos;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  drop;
    logic                  last;
  } acd_entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FETCH,
    B_CAPT,
    B_SCAN,
    B_WRITE,
    B_TSTEP,
    B_TWAIT,
    B_ETRD,
    B_EARD,
    B_EOUT
  } acd_state_t;

endpackage

// ----- design/anchor_chain_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_chain_dp
// Longest chain of k-mer anchors by dynamic programming.
// ----------------------------------------------------------------------------
// Input beats carry one anchor (read_pos, genome_pos) sorted by genome
// position; in_last closes the list. Anchors past MAX_ANCHORS are dropped
// and flagged on every beat of the resulting chain. in_stall rises when the
// four-entry queue in front of the engine is full.
// After the last beat the engine scores anchor i against every earlier anchor
// through a four-stage compare pipeline, one earlier anchor per cycle. The
// best chain is then traced back one anchor at a time through the predecessor
// store and emitted first to last, each beat carrying score, slot, overflow
// and a last marker. A stalled result beat holds in its output register.
// Configuration writes (tuple_size index 0, frac_threshold index 1) are
// always taken; ready is tied high. Reset clears the list and restores
// tuple_size 12 and frac_threshold 13107; no clearing pass is needed.
// ----------------------------------------------------------------------------
module anchor_chain_dp #(
  parameter int MAX_ANCHORS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_read_pos,
  input  logic [31:0]                    in_genome_pos,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_read_pos,
  output logic [31:0]                    out_genome_pos,
  output logic [6:0]                     out_chain_score,
  output logic [5:0]                     out_chain_slot,
  output logic                           out_overflow,
  output logic                           out_last_out
);

  acd_pkg::acd_cfg_t   cfg_r;
  acd_pkg::acd_entry_t push_entry, head;
  logic                push, full, pop, not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tuple_size     <= acd_pkg::TUPLE_SIZE_RST;
      cfg_r.frac_threshold <= acd_pkg::FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == acd_pkg::REG_TUPLE_SIZE) begin
        cfg_r.tuple_size <= cfg_data[7:0];
      end else if (cfg_index == acd_pkg::REG_FRAC_THRESHOLD) begin
        cfg_r.frac_threshold <= cfg_data;
      end
    end
  end

  acd_front #(.MAX_ANCHORS(MAX_ANCHORS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_read_pos, .in_genome_pos, .in_last,
    .q_push(push), .q_entry(push_entry), .q_full(full)
  );

  acd_queue u_queue (
    .clk, .rst_n, .push, .push_entry, .full, .pop, .not_empty, .head
  );

  acd_back #(.MAX_ANCHORS(MAX_ANCHORS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid(not_empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_read_pos, .out_genome_pos, .out_chain_score,
    .out_chain_slot, .out_overflow, .out_last_out
  );

endmodule

// ----- design/acd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module acd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/acd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_queue
// Short fifo of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module acd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  acd_pkg::acd_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output acd_pkg::acd_entry_t head
);

  localparam int PW = $clog2(acd_pkg::QUEUE_DEPTH);

  acd_pkg::acd_entry_t slot_r [acd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full      = (cnt_r == (PW+1)'(acd_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- design/acd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_front
// Accepts anchor beats, assigns store slots and marks beats past capacity.
// ----------------------------------------------------------------------------
module acd_front #(
  parameter int MAX_ANCHORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_read_pos,
  input  logic [31:0]         in_genome_pos,
  input  logic                in_last,
  output logic                q_push,
  output acd_pkg::acd_entry_t q_entry,
  input  logic                q_full
);

  localparam int CW = $clog2(MAX_ANCHORS + 1);

  logic [CW-1:0] cnt_r;
  logic          full_list;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign full_list = (cnt_r == CW'(MAX_ANCHORS));

  always_comb begin
    q_entry.read_pos   = in_read_pos;
    q_entry.genome_pos = in_genome_pos;
    q_entry.addr       = acd_pkg::ADDR_MAX_W'(cnt_r);
    q_entry.drop       = full_list;
    q_entry.last       = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      if (in_last) begin
        cnt_r <= '0;
      end else if (!full_list) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

endmodule

// ----- design/acd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_back
// Stores anchors, runs the chaining scan, traces back and emits the chain.
// ----------------------------------------------------------------------------
module acd_back #(
  parameter int MAX_ANCHORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acd_pkg::acd_cfg_t   cfg,
  input  logic                q_valid,
  input  acd_pkg::acd_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_read_pos,
  output logic [31:0]         out_genome_pos,
  output logic [6:0]          out_chain_score,
  output logic [5:0]          out_chain_slot,
  output logic                out_overflow,
  output logic                out_last_out
);

  localparam int IW = $clog2(MAX_ANCHORS);
  localparam int CW = $clog2(MAX_ANCHORS + 1);

  acd_pkg::acd_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, i_r, j_r, k_r, best_r, prev_s_r;
  logic          ovf_r;
  logic [IW-1:0] bidx_r, idx_r, prev_i_r;
  logic [15:0]   ri_r;
  logic [31:0]   gi_r;

  // scan pipeline
  logic          p1_r, p2_r, p3_r;
  logic [IW-1:0] j1_r, j2_r, j3_r;
  logic [31:0]   lo2_r, hi2_r, lo3_r;
  logic          ok2_r, ok3_r;
  logic [CW-1:0] s2_r, s3_r;
  logic [47:0]   prod3_r;

  // memory ports
  logic          a_we, a_re, s_we, s_re, pr_we, pr_re, t_we, t_re;
  logic [IW-1:0] a_raddr, t_waddr;
  logic [15:0]   rd_dout;
  logic [31:0]   gd_dout;
  logic [CW-1:0] s_dout;
  logic [IW-1:0] p_dout, t_dout;

  logic          issue, scan_done, out_free, out_load, qual, upd_best, last_i;
  logic [17:0]   rd_c;
  logic [33:0]   gd_c;
  logic [31:0]   rdu_c, gdu_c, lo_c, hi_c;
  logic [CW-1:0] new_s;

  logic          out_valid_r, out_last_r, out_ovf_r;
  logic [15:0]   out_rp_r;
  logic [31:0]   out_gp_r;
  logic [6:0]    out_sc_r;
  logic [5:0]    out_sl_r;

  assign issue     = (state_r == acd_pkg::B_SCAN) && (j_r < i_r);
  assign scan_done = (state_r == acd_pkg::B_SCAN) && !issue && !p1_r && !p2_r && !p3_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign new_s     = prev_s_r + CW'(1);
  assign upd_best  = new_s > best_r;
  assign last_i    = (i_r + CW'(1) == cnt_r);
  assign qual      = p3_r && ok3_r && ({lo3_r, 16'b0} > prod3_r);

  // gap arithmetic, exact and signed
  assign rd_c  = {2'b0, ri_r} - {2'b0, rd_dout} - {10'b0, cfg.tuple_size};
  assign gd_c  = {2'b0, gi_r} - {2'b0, gd_dout} - {26'b0, cfg.tuple_size};
  assign rdu_c = {16'b0, rd_c[15:0]};
  assign gdu_c = gd_c[31:0];
  assign lo_c  = (rdu_c < gdu_c) ? rdu_c : gdu_c;
  assign hi_c  = (rdu_c < gdu_c) ? gdu_c : rdu_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acd_pkg::B_IDLE:  if (q_valid && q_head.last) state_nxt = acd_pkg::B_FETCH;
      acd_pkg::B_FETCH: state_nxt = acd_pkg::B_CAPT;
      acd_pkg::B_CAPT:  state_nxt = acd_pkg::B_SCAN;
      acd_pkg::B_SCAN:  if (scan_done) state_nxt = acd_pkg::B_WRITE;
      acd_pkg::B_WRITE: state_nxt = last_i ? acd_pkg::B_TSTEP : acd_pkg::B_FETCH;
      acd_pkg::B_TSTEP: state_nxt = acd_pkg::B_TWAIT;
      acd_pkg::B_TWAIT: state_nxt = (k_r == best_r) ? acd_pkg::B_ETRD : acd_pkg::B_TSTEP;
      acd_pkg::B_ETRD:  state_nxt = acd_pkg::B_EARD;
      acd_pkg::B_EARD:  state_nxt = acd_pkg::B_EOUT;
      acd_pkg::B_EOUT: begin
        if (out_free) begin
          state_nxt = (k_r + CW'(1) == best_r) ? acd_pkg::B_IDLE : acd_pkg::B_ETRD;
        end
      end
      default: state_nxt = acd_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = (state_r == acd_pkg::B_IDLE) && q_valid;
    a_we     = q_pop && !q_head.drop;
    a_re     = 1'b0;
    a_raddr  = j_r[IW-1:0];
    s_re     = issue;
    s_we     = (state_r == acd_pkg::B_WRITE);
    pr_we    = (state_r == acd_pkg::B_WRITE);
    pr_re    = (state_r == acd_pkg::B_TSTEP);
    t_we     = (state_r == acd_pkg::B_TSTEP);
    t_re     = (state_r == acd_pkg::B_ETRD);
    t_waddr  = IW'(best_r - k_r - CW'(1));
    out_load = (state_r == acd_pkg::B_EOUT) && out_free;
    unique case (state_r)
      acd_pkg::B_FETCH: begin
        a_re    = 1'b1;
        a_raddr = i_r[IW-1:0];
      end
      acd_pkg::B_EARD: begin
        a_re    = 1'b1;
        a_raddr = t_dout;
      end
      acd_pkg::B_SCAN: a_re = issue;
      default: a_re = 1'b0;
    endcase
  end

  acd_ram #(.WIDTH(16), .DEPTH(MAX_ANCHORS)) u_read_ram (
    .clk, .we(a_we), .waddr(q_head.addr[IW-1:0]), .wdata(q_head.read_pos),
    .re(a_re), .raddr(a_raddr), .rdata(rd_dout)
  );

  acd_ram #(.WIDTH(32), .DEPTH(MAX_ANCHORS)) u_genome_ram (
    .clk, .we(a_we), .waddr(q_head.addr[IW-1:0]), .wdata(q_head.genome_pos),
    .re(a_re), .raddr(a_raddr), .rdata(gd_dout)
  );

  acd_ram #(.WIDTH(CW), .DEPTH(MAX_ANCHORS)) u_score_ram (
    .clk, .we(s_we), .waddr(i_r[IW-1:0]), .wdata(new_s),
    .re(s_re), .raddr(j_r[IW-1:0]), .rdata(s_dout)
  );

  acd_ram #(.WIDTH(IW), .DEPTH(MAX_ANCHORS)) u_pred_ram (
    .clk, .we(pr_we), .waddr(i_r[IW-1:0]), .wdata(prev_i_r),
    .re(pr_re), .raddr(idx_r), .rdata(p_dout)
  );

  acd_ram #(.WIDTH(IW), .DEPTH(MAX_ANCHORS)) u_trace_ram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(idx_r),
    .re(t_re), .raddr(k_r[IW-1:0]), .rdata(t_dout)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acd_pkg::B_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      best_r      <= '0;
      bidx_r      <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_r    <= issue;
      p2_r    <= p1_r;
      p3_r    <= p2_r;
      if (q_pop) begin
        if (q_head.drop) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= CW'(q_head.addr[IW-1:0]) + CW'(1);
        end
        if (q_head.last) begin
          best_r <= '0;
          bidx_r <= '0;
        end
      end
      if (s_we && upd_best) begin
        best_r <= new_s;
        bidx_r <= i_r[IW-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (k_r + CW'(1) == best_r) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    j1_r    <= j_r[IW-1:0];
    j2_r    <= j1_r;
    s2_r    <= s_dout;
    lo2_r   <= lo_c;
    hi2_r   <= hi_c;
    ok2_r   <= !rd_c[17] && !gd_c[33] && (hi_c != '0);
    j3_r    <= j2_r;
    s3_r    <= s2_r;
    lo3_r   <= lo2_r;
    ok3_r   <= ok2_r;
    prod3_r <= {32'b0, cfg.frac_threshold} * {16'b0, hi2_r};
    if (q_pop && q_head.last) begin
      i_r <= '0;
    end
    if (issue) begin
      j_r <= j_r + CW'(1);
    end
    if (qual && (s3_r > prev_s_r)) begin
      prev_s_r <= s3_r;
      prev_i_r <= j3_r;
    end
    unique case (state_r)
      acd_pkg::B_CAPT: begin
        ri_r     <= rd_dout;
        gi_r     <= gd_dout;
        j_r      <= '0;
        prev_s_r <= '0;
        prev_i_r <= i_r[IW-1:0];
      end
      acd_pkg::B_WRITE: begin
        i_r   <= i_r + CW'(1);
        k_r   <= '0;
        idx_r <= upd_best ? i_r[IW-1:0] : bidx_r;
      end
      acd_pkg::B_TSTEP: k_r <= k_r + CW'(1);
      acd_pkg::B_TWAIT: begin
        idx_r <= p_dout;
        if (k_r == best_r) begin
          k_r <= '0;
        end
      end
      acd_pkg::B_EOUT: begin
        if (out_free) begin
          k_r        <= k_r + CW'(1);
          out_rp_r   <= rd_dout;
          out_gp_r   <= gd_dout;
          out_sc_r   <= 7'(best_r);
          out_sl_r   <= 6'(k_r);
          out_ovf_r  <= ovf_r;
          out_last_r <= (k_r + CW'(1) == best_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_read_pos    = out_rp_r;
  assign out_genome_pos  = out_gp_r;
  assign out_chain_score = out_sc_r;
  assign out_chain_slot  = out_sl_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_out    = out_last_r;

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == acd_pkg::B_TSTEP) |-> (best_r != '0 && best_r <= cnt_r))
    else $error("best score outside list length");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == acd_pkg::B_EOUT) |-> (k_r < best_r))
    else $error("emit slot past chain length");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == acd_pkg::B_WRITE) |-> (!p1_r && !p2_r && !p3_r))
    else $error("score written with scan still in flight");

endmodule
